// ===== src/iss_pkg.sv =====
// Package for the insertion sort block: sizes, widths, cell control and state types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package iss_pkg;

    // Number of cells in the insertion chain.
    localparam int DEPTH     = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // The shift count is summed in groups of eight compare results.
    localparam int GRP_W     = 8;
    localparam int N_GRP     = (DEPTH + GRP_W - 1) / GRP_W;
    localparam int GRP_CNT_W = $clog2(GRP_W + 1);
    localparam int SUM_W     = $clog2(DEPTH + 1);
    localparam int ADD_W     = ((SUM_W > CNT_W) ? SUM_W : CNT_W) + 1;

    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 48;

    typedef struct packed {
        logic ins;    // insert the broadcast value this cycle
        logic drain;  // move every cell one place toward the output
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

endpackage

// ===== src/iss_cell.sv =====
// One cell of the insertion chain: holds one sorted value and its valid bit.
// Depends on iss_pkg.
`timescale 1ns / 1ps
module iss_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iss_pkg::t_cell_ctrl           i_ctrl,
    input  logic signed [iss_pkg::VAL_W-1:0] i_new_value,
    input  logic signed [iss_pkg::VAL_W-1:0] i_prev_value,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_open,
    input  logic signed [iss_pkg::VAL_W-1:0] i_next_value,
    input  logic                          i_next_valid,
    output logic signed [iss_pkg::VAL_W-1:0] o_value,
    output logic                          o_valid,
    output logic                          o_open,
    output logic                          o_gt
);
    import iss_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic                    r_valid;
    logic signed [VAL_W-1:0] n_value;
    logic                    n_valid;

    // A cell is open when it is empty or holds a value greater than the new one;
    // open cells take their left neighbor's value, or the new value if that
    // neighbor stays put.
    assign o_gt   = r_valid && (r_value > i_new_value);
    assign o_open = !r_valid || o_gt;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.drain) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctrl.ins && o_open) begin
            n_value = i_prev_open ? i_prev_value : i_new_value;
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== src/iss_count.sv =====
// Shift counter: two-stage registered popcount of the cells' compare results,
// accumulated into a saturating total. Depends on iss_pkg.
`timescale 1ns / 1ps
module iss_count (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [iss_pkg::DEPTH-1:0] i_gt,
    input  logic                      i_clear,
    output logic [iss_pkg::CNT_W-1:0] o_total
);
    import iss_pkg::*;

    logic [N_GRP*GRP_W-1:0]   gt_pad;
    logic [GRP_CNT_W-1:0]     n_grp [N_GRP];
    logic [GRP_CNT_W-1:0]     r_grp [N_GRP];
    logic [SUM_W-1:0]         grp_sum;
    logic [ADD_W-1:0]         total_wide;
    logic [CNT_W-1:0]         r_total;
    logic [CNT_W-1:0]         n_total;

    always_comb begin
        gt_pad            = '0;
        gt_pad[DEPTH-1:0] = i_gt;
    end

    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                n_grp[g] = n_grp[g] + GRP_CNT_W'(gt_pad[g*GRP_W+b]);
            end
        end
    end

    always_comb begin
        grp_sum = '0;
        for (int g = 0; g < N_GRP; g++) begin
            grp_sum = grp_sum + SUM_W'(r_grp[g]);
        end
        total_wide = ADD_W'(r_total) + ADD_W'(grp_sum);
        if (i_clear) begin
            n_total = '0;
        end else if (total_wide > ADD_W'(CNT_MAX)) begin
            n_total = CNT_MAX;
        end else begin
            n_total = total_wide[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < N_GRP; g++) begin
                r_grp[g] <= '0;
            end
            r_total <= '0;
        end else begin
            for (int g = 0; g < N_GRP; g++) begin
                r_grp[g] <= n_grp[g];
            end
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

// ===== src/insertion_sort_shift_count.sv =====
// Stable insertion sort over a chain of DEPTH cells, with an inversion counter.
// Loading takes one request per cycle: the new value is compared in every cell at once.
// After the request marked last, a flush state lets the two-stage shift counter settle,
// then the held values leave from cell 0, one per cycle while the output is ready.
// No request is taken from the last input until the final result is taken.
// Synchronous active-low reset empties the chain and clears the count and drop flag.
`timescale 1ns / 1ps
module insertion_sort_shift_count (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [iss_pkg::S_DATA_W-1:0]   i_s_tdata,  // [31:0] value
    input  logic                           i_s_tlast,  // is_last
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [iss_pkg::M_DATA_W-1:0]   o_m_tdata,  // [31:0] sorted_value, [42:32] shift_count
    output logic                           o_m_tuser,  // dropped
    output logic                           o_m_tlast   // end_of_run
);
    import iss_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic                    r_dropped;
    logic                    n_dropped;
    t_cell_ctrl              cell_ctrl;
    logic                    s_accept;
    logic                    m_accept;
    logic                    full;
    logic                    run_done;
    logic signed [VAL_W-1:0] new_value;
    logic signed [VAL_W-1:0] cell_value [DEPTH];
    logic                    cell_valid [DEPTH];
    logic                    cell_open  [DEPTH];
    logic [DEPTH-1:0]        cell_gt;
    logic [DEPTH-1:0]        count_gt;
    logic [CNT_W-1:0]        shift_total;

    assign new_value = $signed(i_s_tdata[VAL_W-1:0]);
    assign full      = cell_valid[DEPTH-1];
    assign s_accept  = i_s_tvalid && o_s_tready;
    assign m_accept  = o_m_tvalid && i_m_tready;
    assign run_done  = m_accept && o_m_tlast;

    assign cell_ctrl.ins   = s_accept && !full;
    assign cell_ctrl.drain = m_accept;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            iss_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_new_value  (new_value),
                .i_prev_value (new_value),
                .i_prev_valid (1'b1),
                .i_prev_open  (1'b0),
                .i_next_value (cell_value[1]),
                .i_next_valid (cell_valid[1]),
                .o_value      (cell_value[0]),
                .o_valid      (cell_valid[0]),
                .o_open       (cell_open[0]),
                .o_gt         (cell_gt[0])
            );
        end else if (i == DEPTH - 1) begin : g_tail
            iss_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_new_value  (new_value),
                .i_prev_value (cell_value[i-1]),
                .i_prev_valid (cell_valid[i-1]),
                .i_prev_open  (cell_open[i-1]),
                .i_next_value (cell_value[i]),
                .i_next_valid (1'b0),
                .o_value      (cell_value[i]),
                .o_valid      (cell_valid[i]),
                .o_open       (cell_open[i]),
                .o_gt         (cell_gt[i])
            );
        end else begin : g_mid
            iss_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_new_value  (new_value),
                .i_prev_value (cell_value[i-1]),
                .i_prev_valid (cell_valid[i-1]),
                .i_prev_open  (cell_open[i-1]),
                .i_next_value (cell_value[i+1]),
                .i_next_valid (cell_valid[i+1]),
                .o_value      (cell_value[i]),
                .o_valid      (cell_valid[i]),
                .o_open       (cell_open[i]),
                .o_gt         (cell_gt[i])
            );
        end
    end

    // Only cells that actually shift during an insert add to the count.
    assign count_gt = cell_gt & {DEPTH{cell_ctrl.ins}};

    iss_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gt    (count_gt),
        .i_clear (run_done),
        .o_total (shift_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dropped  = r_dropped;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (s_accept && full) begin
                    n_dropped = 1'b1;
                end
                if (s_accept && i_s_tlast) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                o_m_tvalid = cell_valid[0];
                if (run_done) begin
                    n_state   = ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_m_tdata = {{(M_DATA_W-VAL_W-CNT_W){1'b0}}, shift_total, cell_value[0]};
    assign o_m_tuser = r_dropped;
    assign o_m_tlast = !cell_valid[1];

endmodule
